// ===== rtl/pca_pkg.sv =====
// pca_pkg: widths, mode and register codes, fixed-point constants and the
// channel clamp shared by the colour adjust interfaces and datapath
// depends on nothing
package pca_pkg;

   localparam int CHAN_W     = 8;
   localparam int MODE_W     = 3;
   localparam int AMT_W      = 9;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 9;
   localparam int NCOL       = 3;

   // signed width of sums that still need clamping
   localparam int SUM_W  = 11;
   // contrast: (c - 127) and (amount + 128) as signed factors, and their product
   localparam int FAC_W  = 10;
   localparam int PROD_W = 20;
   localparam int CTR_SHIFT = 7;
   // luma accumulator, q16 weights
   localparam int LUMA_W    = 24;
   localparam int LUMA_FRAC = 16;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [MODE_W-1:0] mode_type;
   typedef logic signed [SUM_W-1:0] sum_type;

   localparam mode_type MODE_BRIGHTNESS = 3'd0;
   localparam mode_type MODE_CONTRAST   = 3'd1;
   localparam mode_type MODE_GRAYSCALE  = 3'd2;
   localparam mode_type MODE_NEGATIVE   = 3'd3;
   localparam mode_type MODE_OPACITY    = 3'd4;
   localparam mode_type MODE_PASS       = 3'd5;

   localparam logic [CSR_IDX_W-1:0] REG_FILTER_MODE   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ADJUST_AMOUNT = 4'd1;

   localparam chan_type                  CHAN_MAX      = 8'd255;
   localparam sum_type                   CHAN_MAX_S    = 11'sd255;
   localparam sum_type                   CTR_MID_S     = 11'sd127;
   localparam logic signed [FAC_W-1:0]   CTR_MID_F     = 10'sd127;
   localparam logic signed [FAC_W-1:0]   CTR_GAIN_BIAS = 10'sd128;
   localparam logic signed [PROD_W-1:0]  CTR_ROUND     = 20'sd127;

   localparam logic [LUMA_W-1:0] LUMA_WR   = 24'd13933;
   localparam logic [LUMA_W-1:0] LUMA_WG   = 24'd46871;
   localparam logic [LUMA_W-1:0] LUMA_WB   = 24'd4732;
   localparam logic [LUMA_W-1:0] LUMA_HALF = 24'd32768;

   function automatic chan_type clamp_chan(input sum_type v);
      chan_type res;
      if (v < 0) begin
         res = '0;
      end else if (v > CHAN_MAX_S) begin
         res = CHAN_MAX;
      end else begin
         res = v[CHAN_W-1:0];
      end
      return res;
   endfunction

endpackage

// ===== rtl/pca_ifs.sv =====
// pca_ifs: valid/ready channels for pixel words in and out, and the
// register write channel
// depends on pca_pkg
interface pca_req_if;
   import pca_pkg::*;
   logic     valid;
   logic     ready;
   chan_type in_red;
   chan_type in_green;
   chan_type in_blue;
   chan_type in_alpha;
   modport source (output valid, in_red, in_green, in_blue, in_alpha, input ready);
   modport sink   (input valid, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface pca_rsp_if;
   import pca_pkg::*;
   logic     valid;
   logic     ready;
   chan_type out_red;
   chan_type out_green;
   chan_type out_blue;
   chan_type out_alpha;
   modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

interface pca_csr_if;
   import pca_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/pixel_color_adjust_top.sv =====
// pixel_color_adjust_top: each accepted pixel word passes through three
// register stages (multiply, add and shift, clamp and mode select) to its
// result word on rsp_chan; throughput one word per clock while rsp_chan is ready
// reset clears the stage valid bits, sets the mode to pass-through and the
// amount to zero; nothing else needs clearing, so words are taken at once
// depends on pca_pkg and pca_ifs
module pixel_color_adjust_top (
   input  logic      clock,
   input  logic      reset,
   pca_req_if.sink   req_chan,
   pca_rsp_if.source rsp_chan,
   pca_csr_if.sink   csr_chan
);
   import pca_pkg::*;

   // configuration registers
   mode_type               filter_mode_ff;
   logic signed [AMT_W-1:0] adjust_amount_ff;

   // stage enables: a stage loads when it is empty or the one after it moves
   logic en1, en2, en3;

   // stage 1: products and raw sums
   logic                     v1_ff;
   chan_type                 pix1_ff [NCOL+1];
   sum_type                  bsum1_ff [NCOL];
   logic signed [PROD_W-1:0] ctr1_ff [NCOL];
   logic [LUMA_W-1:0]        lum1_ff [NCOL];
   sum_type                  asum1_ff;

   // stage 2: brightness and opacity clamped, contrast scaled, luma summed
   logic     v2_ff;
   chan_type pix2_ff [NCOL+1];
   chan_type bclamp2_ff [NCOL];
   sum_type  ctr2_ff [NCOL];
   chan_type luma2_ff;
   chan_type aclamp2_ff;

   // stage 3: output word
   logic     v3_ff;
   chan_type out3_ff [NCOL+1];

   // next values
   chan_type                 col_in [NCOL+1];
   sum_type                  bsum1_in [NCOL];
   logic signed [PROD_W-1:0] ctr1_in [NCOL];
   logic [LUMA_W-1:0]        lum1_in [NCOL];
   sum_type                  asum1_in;
   chan_type                 bclamp2_in [NCOL];
   sum_type                  ctr2_in [NCOL];
   chan_type                 luma2_in;
   chan_type                 aclamp2_in;
   chan_type                 out3_in [NCOL+1];

   sum_type amt_ext;
   logic signed [FAC_W-1:0] ctr_gain;
   logic signed [FAC_W-1:0] ctr_diff [NCOL];
   logic signed [PROD_W-1:0] ctr_biased [NCOL];
   logic signed [PROD_W-1:0] ctr_quot [NCOL];
   logic [LUMA_W-1:0] luma_total;

   assign en3 = !v3_ff || rsp_chan.ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_chan.ready = en1;
   assign csr_chan.ready = 1'b1;

   // ---- configuration writes, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_mode_ff   <= MODE_PASS;
         adjust_amount_ff <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_FILTER_MODE:   filter_mode_ff   <= csr_chan.data[MODE_W-1:0];
            REG_ADJUST_AMOUNT: adjust_amount_ff <= $signed(csr_chan.data[AMT_W-1:0]);
            default: ;
         endcase
      end
   end

   // ---- stage 1
   assign col_in[0] = req_chan.in_red;
   assign col_in[1] = req_chan.in_green;
   assign col_in[2] = req_chan.in_blue;
   assign col_in[3] = req_chan.in_alpha;

   // amount sign-extended; the gain is amount + 128, so -256 gives -128
   assign amt_ext  = {{(SUM_W-AMT_W){adjust_amount_ff[AMT_W-1]}}, adjust_amount_ff};
   assign ctr_gain = {{(FAC_W-AMT_W){adjust_amount_ff[AMT_W-1]}}, adjust_amount_ff}
                     + CTR_GAIN_BIAS;

   always_comb begin
      for (int i = 0; i < NCOL; i++) begin
         bsum1_in[i] = $signed({{(SUM_W-CHAN_W){1'b0}}, col_in[i]}) + amt_ext;
         ctr_diff[i] = $signed({{(FAC_W-CHAN_W){1'b0}}, col_in[i]}) - CTR_MID_F;
         ctr1_in[i]  = ctr_diff[i] * ctr_gain;
      end
      lum1_in[0] = LUMA_W'(col_in[0]) * LUMA_WR;
      lum1_in[1] = LUMA_W'(col_in[1]) * LUMA_WG;
      lum1_in[2] = LUMA_W'(col_in[2]) * LUMA_WB;
      asum1_in   = $signed({{(SUM_W-CHAN_W){1'b0}}, col_in[NCOL]}) + amt_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && req_chan.valid) begin
         pix1_ff  <= col_in;
         bsum1_ff <= bsum1_in;
         ctr1_ff  <= ctr1_in;
         lum1_ff  <= lum1_in;
         asum1_ff <= asum1_in;
      end
   end

   // ---- stage 2
   always_comb begin
      for (int i = 0; i < NCOL; i++) begin
         bclamp2_in[i] = clamp_chan(bsum1_ff[i]);
         // divide by 128 truncating toward zero: bias negatives before the shift
         ctr_biased[i] = ctr1_ff[i] + (ctr1_ff[i][PROD_W-1] ? CTR_ROUND : '0);
         ctr_quot[i]   = ctr_biased[i] >>> CTR_SHIFT;
         ctr2_in[i]    = ctr_quot[i][SUM_W-1:0] + CTR_MID_S;
      end
      // weights sum to one in q16, so the rounded luma always fits a channel
      luma_total = lum1_ff[0] + lum1_ff[1] + lum1_ff[2] + LUMA_HALF;
      luma2_in   = luma_total[LUMA_FRAC +: CHAN_W];
      aclamp2_in = clamp_chan(asum1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2 && v1_ff) begin
         pix2_ff    <= pix1_ff;
         bclamp2_ff <= bclamp2_in;
         ctr2_ff    <= ctr2_in;
         luma2_ff   <= luma2_in;
         aclamp2_ff <= aclamp2_in;
      end
   end

   // ---- stage 3: mode select, unused codes pass the word through
   always_comb begin
      out3_in = pix2_ff;
      case (filter_mode_ff)
         MODE_BRIGHTNESS: begin
            for (int i = 0; i < NCOL; i++) out3_in[i] = bclamp2_ff[i];
         end
         MODE_CONTRAST: begin
            for (int i = 0; i < NCOL; i++) out3_in[i] = clamp_chan(ctr2_ff[i]);
         end
         MODE_GRAYSCALE: begin
            for (int i = 0; i < NCOL; i++) out3_in[i] = luma2_ff;
         end
         MODE_NEGATIVE: begin
            for (int i = 0; i < NCOL; i++) out3_in[i] = CHAN_MAX - pix2_ff[i];
         end
         MODE_OPACITY: begin
            out3_in[NCOL] = aclamp2_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3 && v2_ff) begin
         out3_ff <= out3_in;
      end
   end

   assign rsp_chan.valid     = v3_ff;
   assign rsp_chan.out_red   = out3_ff[0];
   assign rsp_chan.out_green = out3_ff[1];
   assign rsp_chan.out_blue  = out3_ff[2];
   assign rsp_chan.out_alpha = out3_ff[3];

`ifndef SYNTHESIS
   // a word held in stage 1 behind a stall is not dropped
   a_stage1_hold: assert property (@(posedge clock) disable iff (reset)
      v1_ff && !en2 |=> v1_ff)
      else $error("stage 1 word lost during stall");

   // a word held in stage 2 behind a stall is not dropped
   a_stage2_hold: assert property (@(posedge clock) disable iff (reset)
      v2_ff && !en3 |=> v2_ff)
      else $error("stage 2 word lost during stall");

   // an empty first stage always takes a word
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !v1_ff |-> req_chan.ready)
      else $error("input stalled with empty first stage");

   // no result word straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid && !v1_ff && !v2_ff)
      else $error("pipeline not empty after reset");
`endif

endmodule

// ===== tb/sv/pca_tb_pkg.sv =====
// pca_tb_pkg: pixel word type and the colour adjust checker class for the testbench
// holds its own copy of mode and amount and a queue of predicted result words
// depends on pca_pkg
package pca_tb_pkg;
   import pca_pkg::*;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
      chan_type alpha;
   } pixel_word_type;

   // mode codes the block does not define, expected to pass words through
   localparam mode_type MODE_UNUSED_A = 3'd6;
   localparam mode_type MODE_UNUSED_B = 3'd7;

   localparam int LEVEL_MAX  = 255;
   localparam int MID_LEVEL  = 127;
   localparam int GAIN_BIAS  = 128;
   localparam int GAIN_UNITY = 128;
   // rec.709 luma weights in q16, summing to one
   localparam int Y_WEIGHT_R = 13933;
   localparam int Y_WEIGHT_G = 46871;
   localparam int Y_WEIGHT_B = 4732;
   localparam int Y_HALF     = 32768;
   localparam int Y_FRAC     = 16;

   class colour_checker_type;
      mode_type       mode;
      int             amount;
      pixel_word_type expected_pixels[$];
      int             errors;

      function new();
         mode    = MODE_PASS;
         amount  = 0;
         errors  = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == REG_FILTER_MODE) begin
            mode = data[MODE_W-1:0];
         end else if (idx == REG_ADJUST_AMOUNT) begin
            amount = $signed(data[AMT_W-1:0]);
         end
      endfunction

      function chan_type saturate(int v);
         if (v < 0) begin
            return '0;
         end else if (v > LEVEL_MAX) begin
            return chan_type'(LEVEL_MAX);
         end
         return v[CHAN_W-1:0];
      endfunction

      // scale about mid grey, division truncates toward zero
      function chan_type stretch(chan_type c);
         int t;
         t = (int'(c) - MID_LEVEL) * (amount + GAIN_BIAS);
         return saturate(t / GAIN_UNITY + MID_LEVEL);
      endfunction

      function pixel_word_type adjust_pixel(pixel_word_type p);
         pixel_word_type q;
         int             luma;
         q = p;
         case (mode)
            MODE_BRIGHTNESS: begin
               q.red   = saturate(int'(p.red) + amount);
               q.green = saturate(int'(p.green) + amount);
               q.blue  = saturate(int'(p.blue) + amount);
            end
            MODE_CONTRAST: begin
               q.red   = stretch(p.red);
               q.green = stretch(p.green);
               q.blue  = stretch(p.blue);
            end
            MODE_GRAYSCALE: begin
               luma = (Y_WEIGHT_R * int'(p.red) + Y_WEIGHT_G * int'(p.green)
                       + Y_WEIGHT_B * int'(p.blue) + Y_HALF) >> Y_FRAC;
               q.red   = saturate(luma);
               q.green = saturate(luma);
               q.blue  = saturate(luma);
            end
            MODE_NEGATIVE: begin
               q.red   = chan_type'(LEVEL_MAX) - p.red;
               q.green = chan_type'(LEVEL_MAX) - p.green;
               q.blue  = chan_type'(LEVEL_MAX) - p.blue;
            end
            MODE_OPACITY: begin
               q.alpha = saturate(int'(p.alpha) + amount);
            end
            default: begin
            end
         endcase
         return q;
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) begin
            $display("tb: mismatch: %s", msg);
         end
      endfunction

      function void compare_chan(string name, chan_type want, chan_type got);
         if (got !== want) begin
            flag($sformatf("%s expected %0d got %0d (mode %0d amount %0d)",
                           name, want, got, mode, amount));
         end
      endfunction

      function void note_input(pixel_word_type p);
         expected_pixels.push_back(adjust_pixel(p));
      endfunction

      function void check_output(pixel_word_type got);
         pixel_word_type want;
         if (expected_pixels.size() == 0) begin
            flag($sformatf("word %h arrived with nothing expected", got));
            return;
         end
         want = expected_pixels.pop_front();
         compare_chan("red", want.red, got.red);
         compare_chan("green", want.green, got.green);
         compare_chan("blue", want.blue, got.blue);
         compare_chan("alpha", want.alpha, got.alpha);
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

endpackage

// ===== tb/sv/tb.sv =====
// tb: drives pixel words and register writes into pixel_color_adjust_top and
// checks every result word against the colour_checker_type prediction
// depends on pca_pkg, pca_ifs and pca_tb_pkg
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pca_pkg::*;
   import pca_tb_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES      = 40;
   localparam int PHASE_WORDS = 48;
   // phases from here on run with no idling on either side
   localparam int QUIET_FROM  = 34;
   // phase with the long receiver hold-off
   localparam int HOLD_PHASE  = 20;
   localparam int HOLD_LEN    = 150;

   logic clock;
   logic reset;

   pca_req_if req_if();
   pca_rsp_if rsp_if();
   pca_csr_if csr_if();

   pixel_color_adjust_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   colour_checker_type board = new();

   // random idling switch shared by sender and receiver
   bit idle_on = 1'b1;
   // cycles of forced back-pressure still to run, counted down by the receiver
   int hold_left = 0;
   int cycles = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb: done, errors");
      $finish;
   end

   // receiver: long hold when asked, otherwise random stall bursts
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // watch all three channels; note inputs before checking so a word that
   // leaves on the edge it entered is still matched
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) begin
            board.write_reg(csr_if.index, csr_if.data);
         end
         if (req_if.valid && req_if.ready) begin
            board.note_input('{req_if.in_red, req_if.in_green,
                               req_if.in_blue, req_if.in_alpha});
         end
         if (rsp_if.valid && rsp_if.ready) begin
            board.check_output('{rsp_if.out_red, rsp_if.out_green,
                                 rsp_if.out_blue, rsp_if.out_alpha});
         end
      end
   end

   function automatic pixel_word_type pix(int r, int g, int b, int a);
      return '{chan_type'(r), chan_type'(g), chan_type'(b), chan_type'(a)};
   endfunction

   // channel values lean on the rails now and then
   function automatic chan_type random_chan();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return chan_type'(LEVEL_MAX);
         default: return chan_type'($urandom);
      endcase
   endfunction

   function automatic pixel_word_type random_pixel();
      return '{random_chan(), random_chan(), random_chan(), random_chan()};
   endfunction

   // amounts: the two extremes, zero, -128 and -129 where the gain crosses zero, 127, else anything in range
   function automatic int pick_amount();
      case ($urandom_range(0, 9))
         0: return -256;
         1: return 255;
         2: return 0;
         3: return -128;
         4: return -129;
         5: return 127;
         default: return int'($urandom_range(0, 511)) - 256;
      endcase
   endfunction

   // offer one word, keeping valid high from the last one unless a gap is drawn
   task automatic send_pixel(input pixel_word_type p);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 7);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.in_red   <= p.red;
      req_if.in_green <= p.green;
      req_if.in_blue  <= p.blue;
      req_if.in_alpha <= p.alpha;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // stop offering and wait for every outstanding result word
   task automatic settle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // mode writes carry random upper bits, which must be ignored
   task automatic configure(input mode_type m, input int amt);
      logic [CSR_DATA_W-1:0] d;
      d = CSR_DATA_W'($urandom);
      d[MODE_W-1:0] = m;
      write_reg(REG_FILTER_MODE, d);
      write_reg(REG_ADJUST_AMOUNT, amt[CSR_DATA_W-1:0]);
   endtask

   task automatic write_unused_reg();
      write_reg(CSR_IDX_W'($urandom_range(REG_ADJUST_AMOUNT + 1, (1 << CSR_IDX_W) - 1)),
                CSR_DATA_W'($urandom));
   endtask

   initial begin
      int       phase;
      mode_type m;

      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.in_red   <= '0;
      req_if.in_green <= '0;
      req_if.in_blue  <= '0;
      req_if.in_alpha <= '0;
      csr_if.valid    <= 1'b0;
      csr_if.index    <= '0;
      csr_if.data     <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // pass-through straight out of reset
      send_pixel(pix(0, 255, 128, 255));
      send_pixel(pix(255, 0, 1, 0));

      // brightness at both amount extremes, clamping at each rail
      settle();
      configure(MODE_BRIGHTNESS, 255);
      send_pixel(pix(0, 128, 255, 7));
      settle();
      configure(MODE_BRIGHTNESS, -256);
      send_pixel(pix(255, 1, 0, 200));

      // contrast: full inversion at -256, maximum gain, and gain of -1/128
      // where truncation toward zero differs from flooring
      settle();
      configure(MODE_CONTRAST, -256);
      send_pixel(pix(0, 255, 127, 9));
      settle();
      configure(MODE_CONTRAST, 255);
      send_pixel(pix(0, 255, 128, 99));
      settle();
      configure(MODE_CONTRAST, -129);
      send_pixel(pix(0, 255, 126, 3));
      send_pixel(pix(254, 1, 255, 250));

      // grayscale: white, black, pure red and a cyan rounding case
      settle();
      configure(MODE_GRAYSCALE, 255);
      send_pixel(pix(255, 255, 255, 1));
      send_pixel(pix(0, 0, 0, 254));
      send_pixel(pix(255, 0, 0, 128));
      send_pixel(pix(0, 255, 255, 64));

      // negative ignores the amount
      settle();
      configure(MODE_NEGATIVE, -256);
      send_pixel(pix(0, 255, 170, 85));

      // opacity clamps alpha at both ends, colour untouched
      settle();
      configure(MODE_OPACITY, 255);
      send_pixel(pix(12, 34, 56, 10));
      settle();
      configure(MODE_OPACITY, -256);
      send_pixel(pix(200, 100, 50, 255));

      // undefined mode codes behave as pass-through
      settle();
      configure(MODE_UNUSED_A, 255);
      send_pixel(pix(1, 2, 3, 4));
      settle();
      configure(MODE_UNUSED_B, -256);
      send_pixel(pix(250, 251, 252, 253));

      // a write to an unknown register index changes nothing
      settle();
      write_unused_reg();
      send_pixel(pix(255, 255, 0, 0));

      // random phases: first eight walk every mode code, then random settings
      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         m = (phase < 8) ? mode_type'(phase) : mode_type'($urandom_range(0, 7));
         configure(m, pick_amount());
         if ($urandom_range(0, 4) == 0) begin
            write_unused_reg();
         end
         idle_on = (phase < QUIET_FROM);
         if (phase == HOLD_PHASE) begin
            // receiver blocks while the sender keeps pushing, filling the pipe
            idle_on   = 1'b0;
            hold_left = HOLD_LEN;
         end
         repeat (PHASE_WORDS) send_pixel(random_pixel());
      end

      settle();
      repeat (8) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
